### rtl/core/idsu_pkg.sv
// ----------------------------------------------------------------------------
// idsu_pkg: shared types and constants of the interpolating upconverter
// Field widths, fixed-point formats, register codes and the queue entry.
// ----------------------------------------------------------------------------
package idsu_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int LEVEL_W    = 4;
  localparam int FACTOR_W   = 10;
  localparam int T_FRAC     = 24;
  localparam int T_W        = T_FRAC + 1;
  localparam int INV_W      = 25;

  // datapath widths
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int TPROD_W    = FACTOR_W + INV_W;
  localparam int PROD_W     = DIFF_W + T_W + 1;
  localparam int SCALE_W    = PROD_W + LEVEL_W;
  localparam int SHIFT      = T_FRAC + SAMPLE_W - FRAC_W;
  localparam int VALUE_W    = FRAC_W + LEVEL_W + 2;
  localparam int QRAW_W     = VALUE_W - FRAC_W;
  localparam int ERR_W      = FRAC_W + 2;

  localparam logic [TPROD_W-1:0] T_ONE = TPROD_W'(1) << T_FRAC;
  localparam int LEVEL_MID  = 1 << (LEVEL_W - 1);
  localparam int LEVEL_TOP  = (1 << LEVEL_W) - 1;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_FACTOR = 1'b0;
  localparam logic REG_INV    = 1'b1;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'(520);
  localparam logic [INV_W-1:0]    INV_RST    = INV_W'(32264);

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
  } entry_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [INV_W-1:0]    inv;
  } cfg_t;

endpackage

### rtl/core/idsu_if.sv
// ----------------------------------------------------------------------------
// idsu_if: valid/ready channels of the interpolating upconverter
// Input channel carries command and sample, output channel the level.
// ----------------------------------------------------------------------------
interface idsu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [idsu_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

interface idsu_out_if;
  logic                          valid;
  logic                          ready;
  logic [idsu_pkg::LEVEL_W-1:0]  level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

### rtl/core/interpolating_delta_sigma_upconverter.sv
// ----------------------------------------------------------------------------
// interpolating_delta_sigma_upconverter: interpolator with delta-sigma output
// Linear interpolation between held samples, first-order noise shaping.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  item_i    in   valid/ready    command (1b), sample (16b signed)
//  result_o  out  valid/ready    level (4b)
//  apb       in   psel/penable   paddr (3b), pwdata/prdata (32b), pready tied high
//
//  a sample transaction is taken in the idle state, a tick runs four steps
//  (weight multiply, difference multiply, sum, quantize); no new transaction
//  is taken until the tick's quantize step completes
//  a two-entry queue decouples input acceptance from the back end
//  a tick waits in its quantize step while the output register is held
//  reset clears the sample pair, phase, error and registers to their defaults
//
module interpolating_delta_sigma_upconverter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  idsu_in_if.sink                           item_i,
  idsu_out_if.source                        result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [idsu_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [idsu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [idsu_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  idsu_pkg::cfg_t   cfg;
  idsu_pkg::entry_t q_entry;
  logic             q_valid;
  logic             pop;

  assign pready = 1'b1;

  // configuration registers
  idsu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // front end: accept and queue
  idsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .pop_i     (pop),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry)
  );

  // back end: interpolate and quantize
  idsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .pop_o     (pop),
    .result_o  (result_o)
  );

endmodule

### rtl/core/idsu_cfg.sv
// ----------------------------------------------------------------------------
// idsu_cfg: configuration registers
// Holds interpolation factor and its inverse, written over the APB port.
// ----------------------------------------------------------------------------
module idsu_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [idsu_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [idsu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [idsu_pkg::APB_DATA_W-1:0]   prdata,
  output idsu_pkg::cfg_t                    cfg_o
);

  logic [idsu_pkg::FACTOR_W-1:0] factor_q;
  logic [idsu_pkg::INV_W-1:0]    inv_q;
  logic                          wr_en;
  logic                          reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= idsu_pkg::FACTOR_RST;
      inv_q    <= idsu_pkg::INV_RST;
    end else if (wr_en) begin
      case (reg_sel)
        idsu_pkg::REG_FACTOR: factor_q <= pwdata[idsu_pkg::FACTOR_W-1:0];
        idsu_pkg::REG_INV:    inv_q    <= pwdata[idsu_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, misaligned addresses read as zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_sel)
        idsu_pkg::REG_FACTOR: prdata = idsu_pkg::APB_DATA_W'(factor_q);
        idsu_pkg::REG_INV:    prdata = idsu_pkg::APB_DATA_W'(inv_q);
        default:              prdata = '0;
      endcase
    end
  end

  assign cfg_o.factor = factor_q;
  assign cfg_o.inv    = inv_q;

endmodule

### rtl/core/idsu_front.sv
// ----------------------------------------------------------------------------
// idsu_front: input acceptance and command queue
// Classifies each transaction as sample or tick and queues it for the back end.
// ----------------------------------------------------------------------------
module idsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  idsu_in_if.sink          item_i,
  input  logic             pop_i,
  output logic             q_valid_o,
  output idsu_pkg::entry_t q_entry_o
);

  idsu_pkg::entry_t                mem_q [idsu_pkg::QUEUE_DEPTH];
  logic [idsu_pkg::QPTR_W-1:0]     wr_ptr_q;
  logic [idsu_pkg::QPTR_W-1:0]     rd_ptr_q;
  logic [idsu_pkg::QCNT_W-1:0]     count_q;
  logic                            push;
  logic                            pop;
  idsu_pkg::entry_t                new_entry;

  assign item_i.ready = (count_q != idsu_pkg::QCNT_W'(idsu_pkg::QUEUE_DEPTH));
  assign push         = item_i.valid & item_i.ready;
  assign q_valid_o    = (count_q != '0);
  assign pop          = pop_i & q_valid_o;

  // classify the incoming transaction
  assign new_entry.op     = idsu_pkg::op_e'(item_i.command);
  assign new_entry.sample = item_i.sample;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

  assign q_entry_o = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == idsu_pkg::QPTR_W'(idsu_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == idsu_pkg::QPTR_W'(idsu_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### rtl/core/idsu_back.sv
// ----------------------------------------------------------------------------
// idsu_back: interpolator and noise-shaping quantizer
// Updates the sample pair on a sample, runs a four-step sequence per tick.
// ----------------------------------------------------------------------------
module idsu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  idsu_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  idsu_pkg::entry_t q_entry_i,
  output logic             pop_o,
  idsu_out_if.source       result_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_SUM   = 2'd2;
  localparam logic [1:0] ST_QUANT = 2'd3;

  logic [1:0] state_q, state_d;

  // held state
  logic signed [idsu_pkg::SAMPLE_W-1:0] prev_q, latest_q;
  logic [idsu_pkg::FACTOR_W-1:0]        phase_q;
  logic signed [idsu_pkg::ERR_W-1:0]    err_q;

  // pipeline registers of one tick
  logic [idsu_pkg::TPROD_W-1:0]         tprod_q;
  logic signed [idsu_pkg::PROD_W-1:0]   prod_q;
  logic signed [idsu_pkg::PROD_W-1:0]   interp_q;

  // output register
  logic                                 out_valid_q;
  logic [idsu_pkg::LEVEL_W-1:0]         level_q;

  logic                                 is_tick;
  logic                                 done;
  logic [idsu_pkg::T_W-1:0]             t_clamped;
  logic signed [idsu_pkg::DIFF_W-1:0]   diff;
  logic signed [idsu_pkg::PROD_W-1:0]   prev_wide;
  logic signed [idsu_pkg::SCALE_W-1:0]  interp_ext;
  logic signed [idsu_pkg::SCALE_W-1:0]  interp15;
  logic signed [idsu_pkg::SCALE_W-1:0]  scaled_full;
  logic signed [idsu_pkg::VALUE_W-1:0]  value;
  logic signed [idsu_pkg::QRAW_W:0]     q_raw;
  logic [idsu_pkg::LEVEL_W-1:0]         level_d;
  logic signed [idsu_pkg::LEVEL_W:0]    level_ofs;
  logic signed [idsu_pkg::VALUE_W:0]    err_full;
  logic signed [idsu_pkg::ERR_W-1:0]    err_d;

  assign is_tick = (q_entry_i.op == idsu_pkg::OP_TICK);
  assign pop_o   = (state_q == ST_IDLE) & q_valid_i;
  assign done    = (state_q == ST_QUANT) & (~out_valid_q | result_o.ready);

  // interpolation weight, clamped to one
  assign t_clamped = (tprod_q > idsu_pkg::T_ONE) ? idsu_pkg::T_ONE[idsu_pkg::T_W-1:0] :
                     tprod_q[idsu_pkg::T_W-1:0];
  assign diff      = idsu_pkg::DIFF_W'(latest_q) - idsu_pkg::DIFF_W'(prev_q);
  assign prev_wide = idsu_pkg::PROD_W'(prev_q);

  // scale by 15/2^shift and add the fed-back error
  always_comb begin
    interp_ext  = idsu_pkg::SCALE_W'(interp_q);
    interp15    = (interp_ext <<< idsu_pkg::LEVEL_W) - interp_ext;
    scaled_full = interp15 >>> idsu_pkg::SHIFT;
    value       = scaled_full[idsu_pkg::VALUE_W-1:0] + idsu_pkg::VALUE_W'(err_q);
  end

  // quantize with saturation, then the new error
  always_comb begin
    q_raw = (idsu_pkg::QRAW_W+1)'(value >>> idsu_pkg::FRAC_W)
            + (idsu_pkg::QRAW_W+1)'(idsu_pkg::LEVEL_MID);
    if (q_raw < 0) begin
      level_d = '0;
    end else if (q_raw > (idsu_pkg::QRAW_W+1)'(idsu_pkg::LEVEL_TOP)) begin
      level_d = idsu_pkg::LEVEL_W'(idsu_pkg::LEVEL_TOP);
    end else begin
      level_d = q_raw[idsu_pkg::LEVEL_W-1:0];
    end
    level_ofs = $signed({1'b0, level_d}) - (idsu_pkg::LEVEL_W+1)'(idsu_pkg::LEVEL_MID);
    err_full  = (idsu_pkg::VALUE_W+1)'(value)
                - ((idsu_pkg::VALUE_W+1)'(level_ofs) <<< idsu_pkg::FRAC_W);
    if (err_full > (idsu_pkg::VALUE_W+1)'((1 <<< (idsu_pkg::ERR_W - 1)) - 1)) begin
      err_d = {1'b0, {(idsu_pkg::ERR_W-1){1'b1}}};
    end else if (err_full < -(idsu_pkg::VALUE_W+1)'(1 <<< (idsu_pkg::ERR_W - 1))) begin
      err_d = {1'b1, {(idsu_pkg::ERR_W-1){1'b0}}};
    end else begin
      err_d = err_full[idsu_pkg::ERR_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (pop_o && is_tick) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_QUANT;
      ST_QUANT: if (done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      latest_q    <= '0;
      phase_q     <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && !is_tick) begin
        prev_q   <= latest_q;
        latest_q <= q_entry_i.sample;
        phase_q  <= '0;
      end
      if (done) begin
        err_q       <= err_d;
        out_valid_q <= 1'b1;
        if (phase_q < cfg_i.factor) begin
          phase_q <= phase_q + 1'b1;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // tick datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tprod_q <= idsu_pkg::TPROD_W'(phase_q) * idsu_pkg::TPROD_W'(cfg_i.inv);
    end
    if (state_q == ST_MUL) begin
      prod_q <= idsu_pkg::PROD_W'(diff) * idsu_pkg::PROD_W'($signed({1'b0, t_clamped}));
    end
    if (state_q == ST_SUM) begin
      interp_q <= (prev_wide <<< idsu_pkg::T_FRAC) + prod_q;
    end
    if (done) begin
      level_q <= level_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.level = level_q;

endmodule

### rtl/core/idsu_checker.sv
// ----------------------------------------------------------------------------
// idsu_checker: port-level checks of the interpolating upconverter
// Output handshake, queue back-pressure and register read-back.
// ----------------------------------------------------------------------------
module idsu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [idsu_pkg::LEVEL_W-1:0]      out_level_i,
  input logic                              psel_i,
  input logic                              penable_i,
  input logic                              pwrite_i,
  input logic [idsu_pkg::APB_ADDR_W-1:0]   paddr_i,
  input logic [idsu_pkg::APB_DATA_W-1:0]   pwdata_i,
  input logic [idsu_pkg::APB_DATA_W-1:0]   prdata_i
);

  logic wr_factor;

  assign wr_factor = psel_i & penable_i & pwrite_i & (paddr_i == '0);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its level
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_level_i))
    else $error("level changed while stalled");

  // the queue only fills through accepted transactions
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input ready fell without a transaction");

  // factor reads back as written
  a_factor_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_factor |=> (paddr_i != '0 ||
                   prdata_i == idsu_pkg::APB_DATA_W'($past(pwdata_i[idsu_pkg::FACTOR_W-1:0]))))
    else $error("factor read-back mismatch");

endmodule

bind interpolating_delta_sigma_upconverter idsu_checker u_idsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_level_i (result_o.level),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
